// ===== hw/rtl/enc_pkg.sv =====
// Shared constants and types for the eight-neighbour count core.
// Holds field widths, the default matrix side and the register index codes.
// No dependencies.
`timescale 1ns / 1ps

package enc_pkg;

  // Largest matrix side that the line stores hold.
  localparam int MAX_SIDE_DEFAULT = 256;

  // Fixed field widths.
  localparam int CFG_W   = 9;
  localparam int CELL_W  = 32;
  localparam int COUNT_W = 4;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } cfg_index_t;

endpackage

// ===== hw/rtl/eight_neighbour_count_core.sv =====
// Eight-neighbour count core: raster-streamed 3x3 window over a matrix of cells.
// Depends on enc_pkg for widths, the default side and the register index codes.
// Holds the line stores, the window registers and the result register.
`timescale 1ns / 1ps

// The core takes one item per clock cycle when not stalled, each cell of a row_count x
// column_count matrix in row-major order, and gives one result for each cell: the
// count of its eight neighbours that hold exactly 1, with no wrap at the edges. The
// result for a cell leaves in the cycle after the cell below-right of it is taken;
// the last column_count + 1 results (all, for a single-row matrix) come out on flush
// items (mode 1, or any item once the matrix is complete), the final one flagged with
// last_of_matrix. The rate is set by the read-modify-write of the two line stores (one
// read port with a registered, look-ahead read); item_stall rises only while the
// result register is full and stalled, and for one cycle at the start of the flush of
// a single-row matrix. A configuration write drops any matrix in progress.
module eight_neighbour_count_core #(
  parameter int MAX_SIDE = enc_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  enc_pkg::cfg_index_t               cfg_index,
  input  logic [enc_pkg::CFG_W-1:0]         cfg_data,
  // Input item channel.
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              mode,
  input  logic signed [enc_pkg::CELL_W-1:0] cell_value,
  // Result item channel.
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [enc_pkg::COUNT_W-1:0]       neighbour_count,
  output logic                              last_of_matrix
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int ROW_W  = $clog2(MAX_SIDE + 2);
  localparam int COL_W  = $clog2(MAX_SIDE);
  localparam int EXT_W  = (SIDE_W > enc_pkg::CFG_W) ? SIDE_W : enc_pkg::CFG_W;

  // Clamp a written side to the range 1..MAX_SIDE.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [enc_pkg::CFG_W-1:0] v);
    logic [EXT_W-1:0] v_ext;
    logic [SIDE_W-1:0] res;
    v_ext = EXT_W'(v);
    if (v_ext == '0) begin
      res = SIDE_W'(1);
    end else if (v_ext > EXT_W'(MAX_SIDE)) begin
      res = SIDE_W'(MAX_SIDE);
    end else begin
      res = SIDE_W'(v_ext);
    end
    return res;
  endfunction

  // Matrix size registers, held already clamped.
  logic [SIDE_W-1:0] rows;
  logic [SIDE_W-1:0] cols;

  // Position of the cell that the window takes next, and the all-cells-taken flag.
  logic [ROW_W-1:0] row_pos;
  logic [ROW_W-1:0] row_pos_next;
  logic [COL_W-1:0] col_pos;
  logic [COL_W-1:0] col_pos_next;
  logic             in_done;
  logic             in_done_next;

  // Line stores: middle holds the row above the incoming one, upper the row above that.
  logic upper_line_flags  [MAX_SIDE];
  logic middle_line_flags [MAX_SIDE];
  logic upper_rd;
  logic middle_rd;

  // Window columns, bit 2 top, bit 1 middle, bit 0 bottom.
  logic [2:0] win_left;
  logic [2:0] win_center;
  logic [2:0] win_right;

  // Step control.
  logic cfg_write;
  logic item_take;
  logic auto_step;
  logic step_cell;
  logic step;
  logic flag_in;

  // Bounds and result terms.
  logic [ROW_W-1:0] rows_ext;
  logic [COL_W-1:0] col_last;
  logic             col_nonzero;
  logic             top_ok;
  logic             bot_ok;
  logic             left_ok;
  logic             produce;
  logic             is_last;
  logic [enc_pkg::COUNT_W-1:0] count_value;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // A single-row matrix needs one silent window step before its first flush result.
  assign auto_step  = in_done && (row_pos == ROW_W'(1)) && (col_pos == '0);
  assign item_stall = (result_valid && result_stall) || auto_step;
  assign item_take  = item_valid && !item_stall;
  assign step_cell  = item_take && !in_done && !mode;
  assign step       = step_cell || (item_take && in_done) || auto_step;
  assign flag_in    = step_cell && (cell_value == enc_pkg::CELL_W'(1));

  assign rows_ext    = ROW_W'(rows);
  assign col_last    = COL_W'(cols - SIDE_W'(1));
  assign col_nonzero = (col_pos != '0);

  // Incoming column, as seen from the line stores and the input.
  assign win_right = {upper_rd, middle_rd, flag_in};

  // Bounds of the centered cell: one row and column back, or at column zero the end of the row two back.
  always_comb begin
    if (col_nonzero) begin
      produce = (row_pos >= ROW_W'(1));
      top_ok  = (row_pos >= ROW_W'(2));
      bot_ok  = (row_pos < rows_ext);
      left_ok = (col_pos >= COL_W'(2));
    end else begin
      produce = (row_pos >= ROW_W'(2));
      top_ok  = (row_pos >= ROW_W'(3));
      bot_ok  = (row_pos <= rows_ext);
      left_ok = (cols >= SIDE_W'(2));
    end
    is_last = !col_nonzero && (row_pos == rows_ext + ROW_W'(1));
  end

  // Sum of the in-bounds neighbours that hold one.
  always_comb begin
    count_value = '0;
    if (left_ok) begin
      count_value = count_value + enc_pkg::COUNT_W'(win_left[2] && top_ok)
                  + enc_pkg::COUNT_W'(win_left[1])
                  + enc_pkg::COUNT_W'(win_left[0] && bot_ok);
    end
    count_value = count_value + enc_pkg::COUNT_W'(win_center[2] && top_ok)
                + enc_pkg::COUNT_W'(win_center[0] && bot_ok);
    if (col_nonzero) begin
      count_value = count_value + enc_pkg::COUNT_W'(win_right[2] && top_ok)
                  + enc_pkg::COUNT_W'(win_right[1])
                  + enc_pkg::COUNT_W'(win_right[0] && bot_ok);
    end
  end

  // Next position; the final result or a register write starts a new matrix.
  always_comb begin
    row_pos_next = row_pos;
    col_pos_next = col_pos;
    in_done_next = in_done;
    if (cfg_write) begin
      row_pos_next = '0;
      col_pos_next = '0;
      in_done_next = 1'b0;
    end else if (step) begin
      if (produce && is_last) begin
        row_pos_next = '0;
        col_pos_next = '0;
        in_done_next = 1'b0;
      end else begin
        if (col_pos == col_last) begin
          col_pos_next = '0;
          row_pos_next = row_pos + ROW_W'(1);
        end else begin
          col_pos_next = col_pos + COL_W'(1);
        end
        if (step_cell && (col_pos == col_last) &&
            (row_pos == rows_ext - ROW_W'(1))) begin
          in_done_next = 1'b1;
        end
      end
    end
  end

  // Size registers and position state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows    <= SIDE_W'(1);
      cols    <= SIDE_W'(1);
      row_pos <= '0;
      col_pos <= '0;
      in_done <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          enc_pkg::REG_ROW_COUNT:    rows <= clamp_side(cfg_data);
          enc_pkg::REG_COLUMN_COUNT: cols <= clamp_side(cfg_data);
          default: ;
        endcase
      end
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
      in_done <= in_done_next;
    end
  end

  // Line store update: the incoming flag moves in, the older row moves up.
  always_ff @(posedge clk) begin
    if (step) begin
      upper_line_flags[col_pos]  <= middle_rd;
      middle_line_flags[col_pos] <= flag_in;
    end
  end

  // Look-ahead read at the next column, forwarding a write to the same column.
  always_ff @(posedge clk) begin
    if (step && (col_pos_next == col_pos)) begin
      upper_rd  <= middle_rd;
      middle_rd <= flag_in;
    end else begin
      upper_rd  <= upper_line_flags[col_pos_next];
      middle_rd <= middle_line_flags[col_pos_next];
    end
  end

  // Window shift on every step.
  always_ff @(posedge clk) begin
    if (step) begin
      win_left   <= win_center;
      win_center <= win_right;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && produce) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      neighbour_count <= count_value;
      last_of_matrix  <= is_last;
    end
  end

  // The column position stays inside the configured width.
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    ({{(SIDE_W){1'b0}}, col_pos} < {{(COL_W){1'b0}}, cols}))
    else $error("column position beyond column count");

  // While cells are still taken the row is inside the matrix; during flush it is past it.
  a_row_phase: assert property (@(posedge clk) disable iff (rst)
    (in_done ? (row_pos >= rows_ext) : (row_pos < rows_ext)))
    else $error("row position does not match the input phase");

  // The final result returns the core to the start of a new matrix.
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && produce && is_last && !cfg_write) |=>
      (row_pos == '0) && (col_pos == '0) && !in_done)
    else $error("position not cleared after the final result");

  // A result never counts more than eight neighbours.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    (step && produce) |-> (count_value <= enc_pkg::COUNT_W'(8)))
    else $error("neighbour count above eight");

endmodule

// ===== dv/eight_neighbour_count_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for eight_neighbour_count_core: a directed table, then random matrices.
// Depends on enc_pkg and the core; an in-bench predictor tracks line stores and positions.

module eight_neighbour_count_core_test;
  import enc_pkg::*;

  localparam int MAX_SIDE      = MAX_SIDE_DEFAULT;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 200;
  localparam int DIRECTED_ROWS = 28;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               last;
  } count_result_t;

  typedef enum {CHECK_PREDICTED, CHECK_NO_RESULT, CHECK_TYPED} result_check_t;
  typedef enum {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    cfg_index_t        reg_index;
    logic [CFG_W-1:0]  reg_data;
    logic              mode;
    logic [CELL_W-1:0] value;
    result_check_t     check;
    count_result_t     want;
  } directed_row_t;

  // Block ports, all at known values from time zero.
  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  cfg_index_t               cfg_index    = REG_ROW_COUNT;
  logic [CFG_W-1:0]         cfg_data     = '0;
  logic                     item_valid   = 1'b0;
  logic                     item_stall;
  logic                     mode         = 1'b0;
  logic signed [CELL_W-1:0] cell_value   = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [COUNT_W-1:0]       neighbour_count;
  logic                     last_of_matrix;

  // Predictor state: size registers, three row stores and the two positions.
  logic [CFG_W-1:0] rows_reg = 9'd1;
  logic [CFG_W-1:0] cols_reg = 9'd1;
  logic             line_flags [3][MAX_SIDE];
  int               cells_taken   = 0;
  int               results_given = 0;

  count_result_t expected_counts [$];
  directed_row_t directed_rows [DIRECTED_ROWS];

  int send_idle_pct = 13;
  int recv_idle_pct = 77;
  int fail_count    = 0;
  int work_items    = 0;
  int cycle_count   = 0;

  eight_neighbour_count_core #(.MAX_SIDE(MAX_SIDE)) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .mode           (mode),
    .cell_value     (cell_value),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .neighbour_count(neighbour_count),
    .last_of_matrix (last_of_matrix)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // A size register of zero means one; anything above the store depth means the depth.
  function automatic int effective_side(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return int'(raw);
  endfunction

  // Count the in-bounds neighbours of cell j that hold one. The cell arriving this
  // item is not in the stores yet, so its flag is taken directly.
  function automatic logic [COUNT_W-1:0] ones_around(input int j, input int rows, input int cols,
                                                     input bit has_cell, input int cell_idx,
                                                     input logic cell_flag);
    int r, c, nr, nc;
    logic [COUNT_W-1:0] ones;
    r = j / cols;
    c = j % cols;
    ones = '0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = r + dr;
        nc = c + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
          if (has_cell && nr * cols + nc == cell_idx) ones += cell_flag;
          else ones += line_flags[nr % 3][nc];
        end
      end
    end
    return ones;
  endfunction

  // Advance the predictor by one accepted item and give the result it causes, if any.
  task automatic predict_count(input logic item_mode, input logic [CELL_W-1:0] item_value,
                               output bit took_effect, output bit produced,
                               output count_result_t res);
    int rows, cols, total, j;
    logic flag;
    rows        = effective_side(rows_reg);
    cols        = effective_side(cols_reg);
    total       = rows * cols;
    flag        = (item_value == 32'd1);
    took_effect = 1'b0;
    produced    = 1'b0;
    res         = '0;
    if (!item_mode && cells_taken < total) begin
      // A cell: the cell above-left of its lower-right neighbour is now complete.
      took_effect = 1'b1;
      if (cells_taken >= cols + 1) begin
        j             = cells_taken - cols - 1;
        res.count     = ones_around(j, rows, cols, 1'b1, cells_taken, flag);
        res.last      = (j == total - 1);
        results_given = j + 1;
        produced      = 1'b1;
      end
      line_flags[(cells_taken / cols) % 3][cells_taken % cols] = flag;
      cells_taken++;
    end else if (cells_taken >= total && results_given < total) begin
      // A flush, or a surplus cell acting as one, releases the next pending result.
      j         = results_given;
      res.count = ones_around(j, rows, cols, 1'b0, 0, 1'b0);
      res.last  = (j == total - 1);
      results_given++;
      if (results_given >= total) begin
        cells_taken   = 0;
        results_given = 0;
      end
      took_effect = 1'b1;
      produced    = 1'b1;
    end
  endtask

  // Wait until every expected result has come, then let the pipeline settle.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    while (expected_counts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_counts.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_counts.size()));
      expected_counts.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only once the block is idle.
  task automatic write_register(input cfg_index_t idx, input logic [CFG_W-1:0] data);
    if (item_valid) item_valid <= 1'b0;
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_reg = data;
    else cols_reg = data;
    cells_taken   = 0;
    results_given = 0;
  endtask

  // Offer one item after a random gap and record what it is expected to cause.
  task automatic send_item(input logic item_mode, input logic [CELL_W-1:0] item_value,
                           input result_check_t check = CHECK_PREDICTED,
                           input count_result_t typed = '0);
    int gap;
    bit took_effect, produced;
    count_result_t predicted;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    mode       <= item_mode;
    cell_value <= item_value;
    do @(posedge clk); while (item_stall);
    predict_count(item_mode, item_value, took_effect, produced, predicted);
    if (took_effect) work_items++;
    case (check)
      CHECK_PREDICTED: if (produced) expected_counts.push_back(predicted);
      CHECK_TYPED:     expected_counts.push_back(typed);
      default: ;
    endcase
  endtask

  // Cell values lean toward one, with the near misses and full-range noise mixed in.
  function automatic logic [CELL_W-1:0] draw_cell_value();
    case ($urandom_range(7))
      0, 1, 2, 3: return 32'd1;
      4:          return 32'd0;
      5:          return $urandom_range(1) ? 32'hffff_ffff : 32'd2;
      default:    return $urandom;
    endcase
  endfunction

  // One matrix: set the size, stream the cells with stray flushes, then drain.
  // Now and then the matrix is abandoned part way and the next write drops it.
  task automatic run_matrix(input logic [CFG_W-1:0] rows_raw, input logic [CFG_W-1:0] cols_raw);
    int cols, total, stop_at, pending;
    if ($urandom_range(1)) begin
      write_register(REG_ROW_COUNT, rows_raw);
      write_register(REG_COLUMN_COUNT, cols_raw);
    end else begin
      write_register(REG_COLUMN_COUNT, cols_raw);
      write_register(REG_ROW_COUNT, rows_raw);
    end
    cols    = effective_side(cols_raw);
    total   = effective_side(rows_raw) * cols;
    stop_at = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : total;
    for (int k = 0; k < stop_at; k++) begin
      if ($urandom_range(19) == 0) send_item(1'b1, draw_cell_value());
      send_item(1'b0, draw_cell_value());
    end
    if (stop_at == total) begin
      pending = (total < cols + 1) ? total : cols + 1;
      repeat (pending) send_item($urandom_range(3) != 0, draw_cell_value());
      if ($urandom_range(7) == 0) send_item(1'b1, draw_cell_value());
    end
  endtask

  // Result checker and receiver-side stall.
  always @(posedge clk) begin
    count_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d last=%0b",
                                  neighbour_count, last_of_matrix));
      end else begin
        want = expected_counts.pop_front();
        if (neighbour_count !== want.count)
          report_mismatch($sformatf("neighbour_count %0d, expected %0d",
                                    neighbour_count, want.count));
        if (last_of_matrix !== want.last)
          report_mismatch($sformatf("last_of_matrix %0b, expected %0b",
                                    last_of_matrix, want.last));
      end
    end
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [CFG_W-1:0] pick_rows, pick_cols;
    int pick;

    // Directed rows: reset size, an all-ones 3x3, extreme values and a dropped matrix.
    directed_rows = '{
      // 1x1 after reset: the cell, its flush, then a flush with nothing pending.
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b1, 32'd1,         CHECK_TYPED,     '{4'd0, 1'b1}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b1, 32'd1,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      // 3x3 of ones, with an early flush and a surplus cell during the drain.
      '{ROW_WRITE, REG_ROW_COUNT,    9'd3, 1'b0, 32'd0,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_WRITE, REG_COLUMN_COUNT, 9'd3, 1'b0, 32'd0,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_TYPED,     '{4'd3, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b1, 32'hffff_ffff, CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_TYPED,     '{4'd5, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_TYPED,     '{4'd3, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_TYPED,     '{4'd5, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_TYPED,     '{4'd8, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd0,         CHECK_TYPED,     '{4'd5, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b1, 32'd1,         CHECK_TYPED,     '{4'd3, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b1, 32'd0,         CHECK_TYPED,     '{4'd5, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b1, 32'd0,         CHECK_TYPED,     '{4'd3, 1'b1}},
      // 2x2 begun, then dropped by a column write of zero; a 2x1 follows.
      '{ROW_WRITE, REG_ROW_COUNT,    9'd2, 1'b0, 32'd0,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_WRITE, REG_COLUMN_COUNT, 9'd2, 1'b0, 32'd0,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'h8000_0000, CHECK_PREDICTED, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_PREDICTED, '{4'd0, 1'b0}},
      '{ROW_WRITE, REG_COLUMN_COUNT, 9'd0, 1'b0, 32'd0,         CHECK_NO_RESULT, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'h7fff_ffff, CHECK_PREDICTED, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'd1,         CHECK_PREDICTED, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b1, 32'd0,         CHECK_PREDICTED, '{4'd0, 1'b0}},
      '{ROW_ITEM,  REG_ROW_COUNT,    9'd0, 1'b0, 32'hffff_ffff, CHECK_PREDICTED, '{4'd0, 1'b0}}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_WRITE)
        write_register(directed_rows[n].reg_index, directed_rows[n].reg_data);
      else
        send_item(directed_rows[n].mode, directed_rows[n].value,
                  directed_rows[n].check, directed_rows[n].want);
    end

    // Random matrices, mostly small; the idle pattern changes by thirds of the budget.
    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      if (work_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (work_items >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 13;
      end
      pick = $urandom_range(31);
      if (pick == 0) begin
        pick_rows = 9'd0;
        pick_cols = $urandom_range(1, 8);
      end else if (pick == 1) begin
        pick_rows = $urandom_range(1, 6);
        pick_cols = 9'd0;
      end else if (pick == 2) begin
        pick_rows = $urandom_range(256, 511);
        pick_cols = $urandom_range(1);
      end else if (pick == 3) begin
        pick_rows = $urandom_range(1, 2);
        pick_cols = $urandom_range(256, 511);
      end else begin
        pick_rows = $urandom_range(1, 6);
        pick_cols = $urandom_range(1, 8);
      end
      run_matrix(pick_rows, pick_cols);
    end

    // Full-depth sides once each, without idling.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_matrix(9'd256, 9'd0);
    run_matrix(9'd2, 9'd511);

    if (item_valid) item_valid <= 1'b0;
    wait_for_results();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/enc_pkg.sv
hw/rtl/eight_neighbour_count_core.sv
dv/eight_neighbour_count_core_test.sv
